// ===== hdl/ffha_pkg.sv =====
// Package: shared types and constants for the first-fit heap allocator.
package ffha_pkg;

  // Block geometry
  localparam int MAX_BLOCKS_DEF = 32;
  localparam int HEAP_BYTES     = 65536;
  localparam int HEADER_BYTES   = 24;
  localparam int ADDR_SPAN      = 65536;

  // Hard cap on heap growth: least of the heap size and the payload address range
  localparam logic [16:0] HEAP_CAP = 17'((HEAP_BYTES < ADDR_SPAN) ? HEAP_BYTES : ADDR_SPAN);

  // Reset value of the heap_limit register
  localparam logic [16:0] HEAP_LIMIT_RST = 17'(65536);

  // Register byte address bit that selects the register index
  localparam int REG_IDX_BIT = 2;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_ZERO    = 2'd1,
    ST_NOSPACE = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPEND
  } state_e;

  // One block table entry
  typedef struct packed {
    logic [15:0] start;
    logic [15:0] size;
    logic        is_free;
  } entry_t;

endpackage

// ===== hdl/ffha_table.sv =====
// Block table memory: one write port, one read port with registered data.
module ffha_table #(
  parameter int DEPTH = ffha_pkg::MAX_BLOCKS_DEF,
  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IW-1:0]   waddr_i,
  input  ffha_pkg::entry_t wdata_i,
  input  logic [IW-1:0]   raddr_i,
  output ffha_pkg::entry_t rdata_o
);

  ffha_pkg::entry_t mem [DEPTH];
  ffha_pkg::entry_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/first_fit_heap_allocator_top.sv =====
// First-fit heap allocator: address-ordered block table, scanned one entry per cycle while the result register is free.
//
// Each request is taken only while the block is idle. An allocate or free walks
// the block table one entry per clock, while the result register is free, through
// the single read port of the table memory; an allocate that finds no free fit
// then appends a new block at the heap top. Allocation reuses the first free
// entry of sufficient size whole; a free of the topmost block pops it and lowers
// the heap top, any other free only marks the entry free. The result sits in an
// output register, so a new request can be taken while the previous result waits
// to be taken. heap_limit lies at byte address 0 of the register port and should
// be written only while idle.
module first_fit_heap_allocator_top #(
  parameter int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF,
  localparam int IW        = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
  localparam int CW        = $clog2(MAX_BLOCKS + 1)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [15:0] request_size_i,
  input  logic [15:0] block_address_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] result_address_o,
  output logic [1:0]  status_o,
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [17:0] HDR18 = 18'(ffha_pkg::HEADER_BYTES);
  localparam logic [16:0] HDR17 = 17'(ffha_pkg::HEADER_BYTES);
  localparam logic [CW-1:0] MAXB = CW'(MAX_BLOCKS);

  ffha_pkg::state_e state_q, state_d;

  // Register file
  logic [16:0] heap_limit_q;

  // Allocator state
  logic [CW-1:0] count_q, count_d;
  logic [16:0]   top_q, top_d;
  logic [CW-1:0] idx_q, idx_d;

  // Captured request and precomputed operands
  ffha_pkg::cmd_e cmd_q, cmd_d;
  logic [15:0] req_q, req_d;
  logic        addr_zero_q, addr_zero_d;
  logic [15:0] tgt_q, tgt_d;      // block_address - header: start of the block to free
  logic        tgt_ok_q, tgt_ok_d;
  logic [16:0] gap_q, gap_d;      // heap_top - block_address: size of a topmost block
  logic        gap_ok_q, gap_ok_d;
  logic [17:0] total_q, total_d;  // header + request size

  // Result register
  logic        out_valid_q, out_valid_d;
  logic [15:0] res_addr_q, res_addr_d;
  ffha_pkg::status_e status_q, status_d;

  // Table ports
  logic             tbl_we;
  logic [IW-1:0]    tbl_waddr;
  ffha_pkg::entry_t tbl_wdata;
  ffha_pkg::entry_t tbl_rdata;

  // Scratch
  logic        out_free;
  logic [17:0] tgt_diff;
  logic [17:0] gap_diff;
  logic [16:0] res_sum;
  logic [17:0] new_end;
  logic [16:0] lim;
  logic        in_range;

  // Register port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_limit_q <= ffha_pkg::HEAP_LIMIT_RST;
    end else if (psel && penable && pwrite && !paddr[ffha_pkg::REG_IDX_BIT]) begin
      heap_limit_q <= pwdata[16:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (!paddr[ffha_pkg::REG_IDX_BIT]) begin
      prdata = {15'd0, heap_limit_q};
    end
  end

  // Block table
  ffha_table #(
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (idx_d[IW-1:0]),
    .rdata_o (tbl_rdata)
  );

  // Operand precompute at request capture
  assign tgt_diff = {2'd0, block_address_i} - HDR18;
  assign gap_diff = {1'b0, top_q} - {2'd0, block_address_i};

  // Shared arithmetic for the scan and append steps
  assign res_sum  = (state_q == ffha_pkg::S_APPEND) ? (top_q + HDR17)
                                                     : ({1'b0, tbl_rdata.start} + HDR17);
  assign new_end  = {1'b0, top_q} + total_q;
  assign lim      = (heap_limit_q < ffha_pkg::HEAP_CAP) ? heap_limit_q : ffha_pkg::HEAP_CAP;
  assign in_range = idx_q < count_q;
  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer: next state and datapath control
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    top_d       = top_q;
    idx_d       = idx_q;
    cmd_d       = cmd_q;
    req_d       = req_q;
    addr_zero_d = addr_zero_q;
    tgt_d       = tgt_q;
    tgt_ok_d    = tgt_ok_q;
    gap_d       = gap_q;
    gap_ok_d    = gap_ok_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_addr_d  = res_addr_q;
    status_d    = status_q;
    tbl_we      = 1'b0;
    tbl_waddr   = idx_q[IW-1:0];
    tbl_wdata   = tbl_rdata;

    unique case (state_q)
      ffha_pkg::S_IDLE: begin
        idx_d = '0;
        if (in_valid_i) begin
          cmd_d       = ffha_pkg::cmd_e'(cmd_i);
          req_d       = request_size_i;
          addr_zero_d = (block_address_i == 16'd0);
          tgt_d       = tgt_diff[15:0];
          tgt_ok_d    = !tgt_diff[17];
          gap_d       = gap_diff[16:0];
          gap_ok_d    = !gap_diff[17];
          total_d     = HDR18 + {2'd0, request_size_i};
          state_d     = ffha_pkg::S_SCAN;
        end
      end

      ffha_pkg::S_SCAN: begin
        if (out_free) begin
          priority if (cmd_q == ffha_pkg::CMD_ALLOC && req_q == 16'd0) begin
            // zero size refused
            out_valid_d = 1'b1;
            res_addr_d  = '0;
            status_d    = ffha_pkg::ST_ZERO;
            state_d     = ffha_pkg::S_IDLE;
          end else if (cmd_q == ffha_pkg::CMD_FREE && addr_zero_q) begin
            // null free is ignored
            out_valid_d = 1'b1;
            res_addr_d  = '0;
            status_d    = ffha_pkg::ST_DONE;
            state_d     = ffha_pkg::S_IDLE;
          end else if (!in_range) begin
            // end of table: append, or report an unknown address
            if (cmd_q == ffha_pkg::CMD_ALLOC) begin
              state_d = ffha_pkg::S_APPEND;
            end else begin
              out_valid_d = 1'b1;
              res_addr_d  = '0;
              status_d    = ffha_pkg::ST_UNKNOWN;
              state_d     = ffha_pkg::S_IDLE;
            end
          end else if (cmd_q == ffha_pkg::CMD_ALLOC) begin
            if (tbl_rdata.is_free && tbl_rdata.size >= req_q) begin
              // first fit: reuse whole
              tbl_we            = 1'b1;
              tbl_wdata.is_free = 1'b0;
              out_valid_d       = 1'b1;
              res_addr_d        = res_sum[15:0];
              status_d          = ffha_pkg::ST_DONE;
              state_d           = ffha_pkg::S_IDLE;
            end else begin
              idx_d = idx_q + CW'(1);
            end
          end else begin
            if (tgt_ok_q && tbl_rdata.start == tgt_q) begin
              if (gap_ok_q && {1'b0, tbl_rdata.size} == gap_q) begin
                // topmost block: pop it
                top_d   = {1'b0, tbl_rdata.start};
                count_d = idx_q;
              end else begin
                tbl_we            = 1'b1;
                tbl_wdata.is_free = 1'b1;
              end
              out_valid_d = 1'b1;
              res_addr_d  = '0;
              status_d    = ffha_pkg::ST_DONE;
              state_d     = ffha_pkg::S_IDLE;
            end else begin
              idx_d = idx_q + CW'(1);
            end
          end
        end
      end

      ffha_pkg::S_APPEND: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ffha_pkg::S_IDLE;
          if (count_q >= MAXB || new_end > {1'b0, lim}) begin
            res_addr_d = '0;
            status_d   = ffha_pkg::ST_NOSPACE;
          end else begin
            tbl_we            = 1'b1;
            tbl_waddr         = count_q[IW-1:0];
            tbl_wdata.start   = top_q[15:0];
            tbl_wdata.size    = req_q;
            tbl_wdata.is_free = 1'b0;
            count_d           = count_q + CW'(1);
            top_d             = new_end[16:0];
            res_addr_d        = res_sum[15:0];
            status_d          = ffha_pkg::ST_DONE;
          end
        end
      end

      default: begin
        state_d = ffha_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffha_pkg::S_IDLE;
      count_q     <= '0;
      top_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      top_q       <= top_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    req_q       <= req_d;
    addr_zero_q <= addr_zero_d;
    tgt_q       <= tgt_d;
    tgt_ok_q    <= tgt_ok_d;
    gap_q       <= gap_d;
    gap_ok_q    <= gap_ok_d;
    total_q     <= total_d;
    res_addr_q  <= res_addr_d;
    status_q    <= status_d;
  end

  assign in_stall_o       = (state_q != ffha_pkg::S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign result_address_o = res_addr_q;
  assign status_o         = status_q;

endmodule

// ===== test/tb_first_fit_heap_allocator_top.sv =====
// Self-checking testbench for the first-fit heap allocator: directed and random request streams.
module tb_first_fit_heap_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH   = ffha_pkg::MAX_BLOCKS_DEF;
  // Longest request: full table scan plus append and output register
  localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int PHASE_ITEMS   = 300;

  // Register byte addresses
  localparam logic [2:0] REG_HEAP_LIMIT = 3'd0;

  typedef struct {
    logic [15:0]       addr;
    ffha_pkg::status_e status;
  } heap_result_t;

  // DUT connections
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic        cmd_i           = 1'b0;
  logic [15:0] request_size_i  = '0;
  logic [15:0] block_address_i = '0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [15:0] result_address_o;
  logic [1:0]  status_o;
  logic        psel            = 1'b0;
  logic        penable         = 1'b0;
  logic        pwrite          = 1'b0;
  logic [2:0]  paddr           = '0;
  logic [31:0] pwdata          = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the block table, heap top and limit register
  logic [15:0]  blk_start [TABLE_DEPTH];
  logic [15:0]  blk_size  [TABLE_DEPTH];
  bit           blk_free  [TABLE_DEPTH];
  int unsigned  blk_count   = 0;
  int unsigned  top_of_heap = 0;
  int unsigned  limit_reg   = 65536;

  heap_result_t pending_results [$];
  int           error_count = 0;
  bit           steady_flow = 1'b0;
  int           stall_left  = 0;

  first_fit_heap_allocator_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .request_size_i  (request_size_i),
    .block_address_i (block_address_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_address_o(result_address_o),
    .status_o        (status_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Pause length: mostly short, a few long
  function automatic int random_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Apply one request to the shadow table and return what the block must answer
  function automatic heap_result_t apply_heap_op(ffha_pkg::cmd_e op, int unsigned size,
                                                 int unsigned addr);
    heap_result_t res;
    int unsigned  cap;
    int unsigned  total;
    bit           hit;
    res.addr   = '0;
    res.status = ffha_pkg::ST_DONE;
    hit        = 1'b0;
    if (op == ffha_pkg::CMD_ALLOC) begin
      if (size == 0) begin
        res.status = ffha_pkg::ST_ZERO;
      end else begin
        // first fit among free entries, reused whole
        for (int unsigned i = 0; i < blk_count && !hit; i++) begin
          if (blk_free[i] && blk_size[i] >= size) begin
            blk_free[i] = 1'b0;
            res.addr    = 16'(blk_start[i] + ffha_pkg::HEADER_BYTES);
            hit         = 1'b1;
          end
        end
        if (!hit) begin
          cap = limit_reg;
          if (cap > ffha_pkg::HEAP_BYTES) cap = ffha_pkg::HEAP_BYTES;
          if (cap > ffha_pkg::ADDR_SPAN) cap = ffha_pkg::ADDR_SPAN;
          total = ffha_pkg::HEADER_BYTES + size;
          if (blk_count >= TABLE_DEPTH || top_of_heap + total > cap) begin
            res.status = ffha_pkg::ST_NOSPACE;
          end else begin
            blk_start[blk_count] = 16'(top_of_heap);
            blk_size[blk_count]  = 16'(size);
            blk_free[blk_count]  = 1'b0;
            blk_count++;
            res.addr    = 16'(top_of_heap + ffha_pkg::HEADER_BYTES);
            top_of_heap = top_of_heap + total;
          end
        end
      end
    end else if (addr != 0) begin
      res.status = ffha_pkg::ST_UNKNOWN;
      for (int unsigned i = 0; i < blk_count && !hit; i++) begin
        if (blk_start[i] + ffha_pkg::HEADER_BYTES == addr) begin
          hit        = 1'b1;
          res.status = ffha_pkg::ST_DONE;
          // topmost block is popped, any other only marked free
          if (addr + blk_size[i] == top_of_heap) begin
            top_of_heap = blk_start[i];
            blk_count   = i;
          end else begin
            blk_free[i] = 1'b1;
          end
        end
      end
    end
    return res;
  endfunction

  // Result checker and request tracker
  always @(posedge clk_i) begin
    heap_result_t exp_res;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("result with no request waiting: result_address %0d status %0d",
                 result_address_o, status_o);
          error_count++;
        end else begin
          exp_res = pending_results.pop_front();
          if (result_address_o !== exp_res.addr) begin
            $error("result_address: expected %0d, got %0d", exp_res.addr, result_address_o);
            error_count++;
          end
          if (status_o !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, status_o);
            error_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        pending_results.push_back(apply_heap_op(ffha_pkg::cmd_e'(cmd_i),
                                                32'(request_size_i),
                                                32'(block_address_i)));
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    if (steady_flow) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 99) < 30) begin
      stall_left = random_pause() - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Send one request, after an optional gap, and wait until it is taken
  task automatic send_request(ffha_pkg::cmd_e op, logic [15:0] size, logic [15:0] addr);
    int gap;
    gap = 0;
    if (!steady_flow && $urandom_range(0, 99) < 50) gap = random_pause();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= op;
    request_size_i  <= size;
    block_address_i <= addr;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
  endtask

  // Stop sending, wait for every outstanding result, then let the block go idle
  task automatic settle();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One APB transfer to the heap_limit register; psel is left high
  task automatic reg_access(bit wr, logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= REG_HEAP_LIMIT;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
  endtask

  // Write heap_limit while idle and read it back
  task automatic write_heap_limit(int unsigned value);
    logic [31:0] rd;
    settle();
    reg_access(1'b1, value, rd);
    limit_reg = value & 32'h1FFFF;
    reg_access(1'b0, '0, rd);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[16:0] !== limit_reg[16:0]) begin
      $error("heap_limit: expected %0d, got %0d", limit_reg, rd[16:0]);
      error_count++;
    end
  endtask

  // Free every live block from the top down so that each one is popped
  task automatic release_all_blocks();
    logic [15:0] addrs [$];
    settle();
    for (int i = int'(blk_count) - 1; i >= 0; i--) begin
      addrs.push_back(16'(blk_start[i] + ffha_pkg::HEADER_BYTES));
    end
    foreach (addrs[k]) send_request(ffha_pkg::CMD_FREE, 16'($urandom()), addrs[k]);
  endtask

  task automatic test_register_port();
    logic [31:0] rd;
    reg_access(1'b0, '0, rd);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[16:0] !== ffha_pkg::HEAP_LIMIT_RST) begin
      $error("heap_limit reset: expected %0d, got %0d", ffha_pkg::HEAP_LIMIT_RST, rd[16:0]);
      error_count++;
    end
    write_heap_limit(32'h1FFFF);
    write_heap_limit(0);
    write_heap_limit(65536);
  endtask

  task automatic test_directed_cases();
    send_request(ffha_pkg::CMD_ALLOC, 16'd0, 16'hFFFF);      // zero size
    send_request(ffha_pkg::CMD_FREE, 16'hFFFF, 16'd0);       // null free
    send_request(ffha_pkg::CMD_FREE, 16'd0, 16'hFFFF);       // unknown address
    send_request(ffha_pkg::CMD_FREE, 16'd0, 16'd24);         // nothing allocated yet
    send_request(ffha_pkg::CMD_ALLOC, 16'hFFFF, 16'd0);      // larger than the heap
    send_request(ffha_pkg::CMD_ALLOC, 16'd65512, 16'd0);     // fills the heap exactly
    send_request(ffha_pkg::CMD_ALLOC, 16'd1, 16'd0);         // heap exhausted
    send_request(ffha_pkg::CMD_FREE, 16'd0, 16'd24);         // pops the only block
    send_request(ffha_pkg::CMD_ALLOC, 16'd1, 16'd0);
    send_request(ffha_pkg::CMD_ALLOC, 16'd100, 16'd0);
    send_request(ffha_pkg::CMD_ALLOC, 16'd16, 16'd0);
    send_request(ffha_pkg::CMD_FREE, 16'd0, 16'd24);         // marked free, not at top
    send_request(ffha_pkg::CMD_FREE, 16'd0, 16'd24);         // double free
    send_request(ffha_pkg::CMD_FREE, 16'd0, 16'd50);         // inside a block
    send_request(ffha_pkg::CMD_ALLOC, 16'd2, 16'd0);         // free entry too small, append
    send_request(ffha_pkg::CMD_ALLOC, 16'd1, 16'd0);         // reuses first entry
    send_request(ffha_pkg::CMD_FREE, 16'd0, 16'd49);
    send_request(ffha_pkg::CMD_ALLOC, 16'd100, 16'd0);       // exact-size reuse
    send_request(ffha_pkg::CMD_FREE, 16'd0, 16'd213);        // pops top block
    send_request(ffha_pkg::CMD_FREE, 16'd0, 16'd213);        // popped address now unknown
    send_request(ffha_pkg::CMD_FREE, 16'd0, 16'd173);
    release_all_blocks();
  endtask

  task automatic test_heap_limit();
    release_all_blocks();
    write_heap_limit(0);
    send_request(ffha_pkg::CMD_ALLOC, 16'd1, 16'd0);
    send_request(ffha_pkg::CMD_ALLOC, 16'hFFFF, 16'd0);
    // limit that fits one header plus five bytes
    write_heap_limit(ffha_pkg::HEADER_BYTES + 5);
    send_request(ffha_pkg::CMD_ALLOC, 16'd5, 16'd0);
    send_request(ffha_pkg::CMD_ALLOC, 16'd1, 16'd0);
    send_request(ffha_pkg::CMD_FREE, 16'd0, 16'(ffha_pkg::HEADER_BYTES));
    send_request(ffha_pkg::CMD_ALLOC, 16'd6, 16'd0);
    send_request(ffha_pkg::CMD_ALLOC, 16'd5, 16'd0);
    release_all_blocks();
    // oversized value acts as the full address range
    write_heap_limit(32'h1FFFF);
    send_request(ffha_pkg::CMD_ALLOC, 16'hFFFF, 16'd0);
    send_request(ffha_pkg::CMD_ALLOC, 16'd65512, 16'd0);
    release_all_blocks();
    write_heap_limit(65536);
  endtask

  task automatic test_table_full();
    logic [15:0] mid_addr;
    release_all_blocks();
    repeat (TABLE_DEPTH + 1) send_request(ffha_pkg::CMD_ALLOC, 16'd1, 16'($urandom()));
    send_request(ffha_pkg::CMD_ALLOC, 16'd2, 16'd0);
    settle();
    mid_addr = 16'(blk_start[TABLE_DEPTH / 2] + ffha_pkg::HEADER_BYTES);
    send_request(ffha_pkg::CMD_FREE, 16'd0, mid_addr);
    send_request(ffha_pkg::CMD_ALLOC, 16'd2, 16'd0);         // too small, table full
    send_request(ffha_pkg::CMD_ALLOC, 16'd1, 16'd0);         // reuses the freed entry
    release_all_blocks();
  endtask

  task automatic test_random_traffic();
    int unsigned phase_limit [7];
    int          alloc_pct;
    int          r;
    int unsigned cnt;
    int unsigned idx;
    logic [15:0] size;
    logic [15:0] addr;
    phase_limit = '{65536, 32'h1FFFF, 2000, 600, 65536, 0, 65536};
    phase_limit[5] = $urandom_range(0, 32'h1FFFF);
    for (int p = 0; p < 7; p++) begin
      write_heap_limit(phase_limit[p]);
      steady_flow = (p == 4);
      alloc_pct   = 60;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) alloc_pct = $urandom_range(25, 85);
        // sender holds off until everything has come back
        if (n % 150 == 149) settle();
        if ($urandom_range(0, 99) < alloc_pct) begin
          r = $urandom_range(0, 99);
          if (r < 3) size = '0;
          else if (r < 8) size = 16'($urandom());
          else if (r < 65) size = 16'($urandom_range(1, 64));
          else if (r < 92) size = 16'($urandom_range(1, 1024));
          else size = 16'($urandom_range(1, 8192));
          send_request(ffha_pkg::CMD_ALLOC, size, 16'($urandom()));
        end else begin
          r   = $urandom_range(0, 99);
          cnt = blk_count;
          if (r < 80 && cnt > 0) begin
            idx  = (r < 30) ? cnt - 1 : $urandom_range(0, cnt - 1);
            addr = 16'(blk_start[idx] + ffha_pkg::HEADER_BYTES);
          end else if (r < 88) begin
            addr = '0;
          end else begin
            addr = 16'($urandom());
          end
          send_request(ffha_pkg::CMD_FREE, 16'($urandom()), addr);
        end
      end
      steady_flow = 1'b0;
    end
  endtask

  // Test sequence
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_port();
    test_directed_cases();
    test_heap_limit();
    test_table_full();
    test_random_traffic();
    settle();
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("first_fit_heap_allocator_top verification clean");
    end else begin
      $display("first_fit_heap_allocator_top verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30_000_000;
    $display("first_fit_heap_allocator_top verification failed");
    $finish;
  end

endmodule
